@@ design/pbdec_pkg.sv @@
`timescale 1ns / 1ps

package pbdec_pkg;

  // A header byte with this bit set announces a literal run.
  localparam logic [7:0] RunFlag = 8'h80;
  // Literal count is the header minus this bias.
  localparam logic [7:0] LitBias = 8'd127;

  // Status codes carried in a status result.
  localparam logic StatusOk        = 1'b0;
  localparam logic StatusTruncated = 1'b1;

  // Decoder phase, one-hot.
  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_REPEAT  = 3'b010,
    PH_LITERAL = 3'b100
  } phase_e;

  // One compressed input word.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } item_t;

  // One decoded result word.
  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] copies;
    logic       is_status;
    logic       status;
  } result_t;

endpackage

@@ design/packbits_run_length_decoder_top.sv @@
// A word accepted into the input register is decoded, and its result is
// registered in the output register.
// Throughput: one word per cycle while the output is not stalled, set by the
// input and output registers around one decode step; header words give no result.
// Reset (rst_ni low, asynchronous): both registers empty, header phase.
`timescale 1ns / 1ps

module packbits_run_length_decoder_top
  import pbdec_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [7:0] copies_o,
  output logic       is_status_o,
  output logic       status_o
);

  logic    item_valid;
  item_t   item;
  logic    take;
  result_t result;

  // Input register.
  pbdec_in_reg u_in_reg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .end_of_input_i (end_of_input_i),
    .item_valid_o   (item_valid),
    .item_o         (item),
    .take_i         (take)
  );

  // Decode state and output register.
  pbdec_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_o     (result)
  );

  assign out_byte_o  = result.out_byte;
  assign copies_o    = result.copies;
  assign is_status_o = result.is_status;
  assign status_o    = result.status;

endmodule

@@ design/pbdec_in_reg.sv @@
`timescale 1ns / 1ps

module pbdec_in_reg
  import pbdec_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  logic  [7:0] data_byte_i,
  input  logic  end_of_input_i,
  output logic  item_valid_o,
  output item_t item_o,
  input  logic  take_i
);

  logic  valid_q;
  item_t item_q;
  logic  accept;

  // The register takes a new word whenever it is empty or its word moves on.
  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.data_byte    <= data_byte_i;
      item_q.end_of_input <= end_of_input_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

@@ design/pbdec_core.sv @@
`timescale 1ns / 1ps

module pbdec_core
  import pbdec_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    take_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t result_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] run_left_q, run_left_d;
  logic       res_valid;
  result_t    res;
  logic       out_valid_q;
  result_t    result_q;
  logic       out_free;

  // Decode one word against the current phase.
  always_comb begin
    phase_d    = phase_q;
    run_left_d = run_left_q;
    res_valid  = 1'b0;
    res        = '0;
    if (item_i.end_of_input) begin
      res_valid     = 1'b1;
      res.is_status = 1'b1;
      res.status    = (phase_q != PH_HEADER) ? StatusTruncated : StatusOk;
      phase_d       = PH_HEADER;
      run_left_d    = '0;
    end else begin
      case (phase_q)
        PH_REPEAT: begin
          res_valid    = 1'b1;
          res.out_byte = item_i.data_byte;
          res.copies   = run_left_q + 8'd1;
          phase_d      = PH_HEADER;
          run_left_d   = '0;
        end
        PH_LITERAL: begin
          res_valid    = 1'b1;
          res.out_byte = item_i.data_byte;
          res.copies   = 8'd1;
          run_left_d   = run_left_q - 8'd1;
          if (run_left_q == 8'd1) begin
            phase_d = PH_HEADER;
          end
        end
        default: begin
          // Header word: sets up the next run and gives no result.
          if ((item_i.data_byte & RunFlag) != 8'd0) begin
            run_left_d = item_i.data_byte - LitBias;
            phase_d    = PH_LITERAL;
          end else begin
            run_left_d = item_i.data_byte;
            phase_d    = PH_REPEAT;
          end
        end
      endcase
    end
  end

  // A word moves on unless it has a result and the output register is held.
  assign out_free = !out_valid_q || !out_stall_i;
  assign take_o   = item_valid_i && (!res_valid || out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      run_left_q <= '0;
    end else if (take_o) begin
      phase_q    <= phase_d;
      run_left_q <= run_left_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= take_o && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && res_valid) begin
      result_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

@@ design/pbdec_checker.sv @@
`timescale 1ns / 1ps

module pbdec_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_stall_i,
  input logic [7:0] out_byte_i,
  input logic [7:0] copies_i,
  input logic       is_status_i,
  input logic       status_i
);

  // A held result word keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_byte_i) &&
      $stable(copies_i) && $stable(is_status_i) && $stable(status_i))
    else $error("result word changed while stalled");

  // A status word carries no byte and no count.
  a_status_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_status_i |-> out_byte_i == 8'd0 && copies_i == 8'd0)
    else $error("status word carries data");

  // A data word has a nonzero count and a clear status bit.
  a_data_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !is_status_i |-> copies_i != 8'd0 && !status_i)
    else $error("data word with bad count or status");

  // Counts never exceed 128.
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && copies_i[7] |-> copies_i[6:0] == 7'd0)
    else $error("copy count above 128");

endmodule

bind packbits_run_length_decoder_top pbdec_checker u_pbdec_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_byte_i  (out_byte_o),
  .copies_i    (copies_o),
  .is_status_i (is_status_o),
  .status_i    (status_o)
);
